// File: rtl/rational_bezier_curve_evaluator_unit_assert.svh
// assertion macros for the rational bezier evaluator
`ifndef RATIONAL_BEZIER_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`define RATIONAL_BEZIER_CURVE_EVALUATOR_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define RBEZ_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// condition holds in the next cycle
`define RBEZ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: rtl/rbez_pkg.sv
// shared constants, types and rounding for the rational bezier evaluator
package rbez_pkg;
	localparam int POINTS = 8;
	localparam int IDX_W = $clog2(POINTS);
	localparam int COORD_W = 32;
	localparam int WGT_W = 15;
	localparam int U_W = 17;
	localparam int DEG_W = 3;
	localparam int VAL_W = COORD_W + WGT_W + 1;
	localparam int PROD_W = VAL_W + U_W + 1;
	localparam int AXES = 4;
	localparam int H_W = 32;
	localparam int Q_W = 64;
	localparam logic [U_W-1:0] U_ONE = U_W'(65536);
	localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(3);

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
	} ctrl_t;

	// divide by 2^16, nearest, ties away from zero
	function automatic val_t round16(input logic signed [PROD_W:0] v);
		logic [PROD_W:0] m;
		logic [PROD_W:0] r;
		begin
			if (v[PROD_W]) begin
				m = (PROD_W+1)'(-v);
				r = (m + (PROD_W+1)'(32768)) >> 16;
				round16 = VAL_W'(-r);
			end else begin
				r = ($unsigned(v) + (PROD_W+1)'(32768)) >> 16;
				round16 = VAL_W'(r);
			end
		end
	endfunction
endpackage

// File: rtl/rbez_cell.sv
// one de casteljau cell: holds a weighted point and blends it with its neighbor
module rbez_cell (
	input  logic                                clk,
	input  rbez_pkg::ctrl_t                     ctrl,
	input  logic signed [rbez_pkg::COORD_W-1:0] ld_x,
	input  logic signed [rbez_pkg::COORD_W-1:0] ld_y,
	input  logic signed [rbez_pkg::COORD_W-1:0] ld_z,
	input  logic        [rbez_pkg::WGT_W-1:0]   ld_w,
	input  logic        [rbez_pkg::U_W-1:0]     u,
	input  rbez_pkg::val_t                      nb [rbez_pkg::AXES],
	output rbez_pkg::val_t                      own [rbez_pkg::AXES]
);
	rbez_pkg::val_t v_q [rbez_pkg::AXES];
	logic signed [rbez_pkg::PROD_W-1:0] pa_q [rbez_pkg::AXES];
	logic signed [rbez_pkg::PROD_W-1:0] pb_q [rbez_pkg::AXES];
	logic [rbez_pkg::U_W-1:0] inv_u;
	logic signed [rbez_pkg::WGT_W:0] w_s;

	assign inv_u = rbez_pkg::U_ONE - u;
	assign w_s = $signed({1'b0, ld_w});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q[0] <= rbez_pkg::VAL_W'(ld_x * w_s);
			v_q[1] <= rbez_pkg::VAL_W'(ld_y * w_s);
			v_q[2] <= rbez_pkg::VAL_W'(ld_z * w_s);
			v_q[3] <= rbez_pkg::VAL_W'({ld_w, 16'b0});
		end
		for (int k = 0; k < rbez_pkg::AXES; k++) begin
			if (ctrl.mul) begin
				pa_q[k] <= v_q[k] * $signed({1'b0, inv_u});
				pb_q[k] <= nb[k] * $signed({1'b0, u});
			end
			if (ctrl.add) begin
				v_q[k] <= rbez_pkg::round16({pa_q[k][rbez_pkg::PROD_W-1], pa_q[k]}
					+ {pb_q[k][rbez_pkg::PROD_W-1], pb_q[k]});
			end
		end
	end

	assign own = v_q;
endmodule

// File: rtl/rbez_div.sv
// two bits per cycle restoring divider with rounding bias and saturation
module rbez_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  rbez_pkg::val_t                      c,
	input  logic        [rbez_pkg::H_W-1:0]     h,
	output logic                                done,
	output logic signed [rbez_pkg::COORD_W-1:0] q
);
	localparam int CNT_W = $clog2(rbez_pkg::Q_W / 2);
	logic [rbez_pkg::Q_W-1:0] n_q, n_d;
	logic [rbez_pkg::H_W-1:0] r_q, r_d;
	logic [CNT_W-1:0] cnt_q;
	logic run_q, neg_q, done_q;
	logic [rbez_pkg::VAL_W-1:0] mag;
	localparam logic [rbez_pkg::Q_W-1:0] POS_MAX = rbez_pkg::Q_W'((64'd1 << (rbez_pkg::COORD_W-1)) - 1);
	localparam logic [rbez_pkg::Q_W-1:0] NEG_MAX = rbez_pkg::Q_W'(64'd1 << (rbez_pkg::COORD_W-1));

	assign mag = c[rbez_pkg::VAL_W-1] ? rbez_pkg::VAL_W'(-c) : $unsigned(c);

	always_comb begin
		logic [rbez_pkg::H_W:0] t;
		n_d = n_q;
		r_d = r_q;
		for (int s = 0; s < 2; s++) begin
			t = {r_d, n_d[rbez_pkg::Q_W-1]};
			n_d = {n_d[rbez_pkg::Q_W-2:0], 1'b0};
			if (t >= {1'b0, h}) begin
				t = t - {1'b0, h};
				n_d[0] = 1'b1;
			end
			r_d = t[rbez_pkg::H_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(rbez_pkg::Q_W / 2 - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= c[rbez_pkg::VAL_W-1];
			n_q <= (rbez_pkg::Q_W'(mag) << 16) + rbez_pkg::Q_W'(h >> 1);
			r_q <= '0;
		end else if (run_q) begin
			n_q <= n_d;
			r_q <= r_d;
		end
	end

	always_comb begin
		if (neg_q) begin
			q = (n_q > NEG_MAX) ? $signed(NEG_MAX[rbez_pkg::COORD_W-1:0])
				: $signed(rbez_pkg::COORD_W'(-n_q[rbez_pkg::COORD_W-1:0]));
		end else begin
			q = (n_q > POS_MAX) ? $signed(POS_MAX[rbez_pkg::COORD_W-1:0])
				: $signed(n_q[rbez_pkg::COORD_W-1:0]);
		end
	end

	assign done = done_q;
endmodule

// File: rtl/rational_bezier_curve_evaluator_unit.sv
// rational bezier evaluator: a load writes the point store; an evaluate weights the points,
// runs two steps (multiply, add) per de casteljau level in the cell row, starts the
// division, waits for the two-bit-per-cycle division and registers the result
// one item at a time; a zero weight sum skips the division; the result strobe lasts one cycle
// reset sets the degree to 3 and idles the block; the point store is not cleared
module rational_bezier_curve_evaluator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_we,
	input  logic        [rbez_pkg::DEG_W-1:0]   cfg_wdata,
	input  logic                                opcode,
	input  logic        [2:0]                   point_index,
	input  logic signed [rbez_pkg::COORD_W-1:0] coord_x,
	input  logic signed [rbez_pkg::COORD_W-1:0] coord_y,
	input  logic signed [rbez_pkg::COORD_W-1:0] coord_z,
	input  logic        [rbez_pkg::WGT_W-1:0]   point_weight,
	input  logic        [rbez_pkg::U_W-1:0]     param_u,
	output logic signed [rbez_pkg::COORD_W-1:0] curve_x,
	output logic signed [rbez_pkg::COORD_W-1:0] curve_y,
	output logic signed [rbez_pkg::COORD_W-1:0] curve_z,
	output logic                                zero_weight_sum
);
	`include "rational_bezier_curve_evaluator_unit_assert.svh"

	localparam int P = rbez_pkg::POINTS;
	localparam int IW = rbez_pkg::IDX_W;

	typedef enum logic [2:0] {S_IDLE, S_INIT, S_MUL, S_ADD, S_DIV, S_WAIT} state_t;
	state_t state_q;

	logic [rbez_pkg::DEG_W-1:0] degree_q;
	logic [IW-1:0] deg_q, lvl_q;
	logic [rbez_pkg::U_W-1:0] u_q;
	logic accept;
	logic div_start;
	logic [2:0] div_done;
	logic signed [rbez_pkg::COORD_W-1:0] qx, qy, qz;
	rbez_pkg::ctrl_t ctrl;

	logic signed [rbez_pkg::COORD_W-1:0] st_x [P];
	logic signed [rbez_pkg::COORD_W-1:0] st_y [P];
	logic signed [rbez_pkg::COORD_W-1:0] st_z [P];
	logic [rbez_pkg::WGT_W-1:0] st_w [P];

	rbez_pkg::val_t own [P][rbez_pkg::AXES];
	rbez_pkg::val_t zero_v [rbez_pkg::AXES];
	logic [rbez_pkg::H_W-1:0] h;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign ctrl.load = state_q == S_INIT;
	assign ctrl.mul = state_q == S_MUL;
	assign ctrl.add = state_q == S_ADD;
	assign div_start = state_q == S_DIV && h != '0;
	assign h = own[0][3][rbez_pkg::H_W-1:0];
	always_comb for (int k = 0; k < rbez_pkg::AXES; k++) zero_v[k] = '0;

	always_ff @(posedge clk) begin
		if (accept && !opcode && int'(point_index) < P) begin
			st_x[IW'(point_index)] <= coord_x;
			st_y[IW'(point_index)] <= coord_y;
			st_z[IW'(point_index)] <= coord_z;
			st_w[IW'(point_index)] <= point_weight;
		end
		if (accept && opcode) begin
			u_q <= (param_u > rbez_pkg::U_ONE) ? rbez_pkg::U_ONE : param_u;
			deg_q <= (int'(degree_q) > P - 1) ? IW'(P - 1) : IW'(degree_q);
		end
	end

	for (genvar g = 0; g < P; g++) begin : g_cell
		if (g < P - 1) begin : g_mid
			rbez_cell u_cell (.clk, .ctrl, .ld_x(st_x[g]), .ld_y(st_y[g]), .ld_z(st_z[g]),
				.ld_w(st_w[g]), .u(u_q), .nb(own[g+1]), .own(own[g]));
		end else begin : g_end
			rbez_cell u_cell (.clk, .ctrl, .ld_x(st_x[g]), .ld_y(st_y[g]), .ld_z(st_z[g]),
				.ld_w(st_w[g]), .u(u_q), .nb(zero_v), .own(own[g]));
		end
	end

	rbez_div u_div_x (.clk, .arst_n, .start(div_start), .c(own[0][0]), .h,
		.done(div_done[0]), .q(qx));
	rbez_div u_div_y (.clk, .arst_n, .start(div_start), .c(own[0][1]), .h,
		.done(div_done[1]), .q(qy));
	rbez_div u_div_z (.clk, .arst_n, .start(div_start), .c(own[0][2]), .h,
		.done(div_done[2]), .q(qz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			degree_q <= rbez_pkg::DEG_RESET;
			lvl_q <= '0;
			done <= 1'b0;
			zero_weight_sum <= 1'b0;
			curve_x <= '0;
			curve_y <= '0;
			curve_z <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) degree_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: if (accept && opcode) state_q <= S_INIT;
				S_INIT: begin
					lvl_q <= '0;
					state_q <= (deg_q == '0) ? S_DIV : S_MUL;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					lvl_q <= lvl_q + 1'b1;
					state_q <= (lvl_q + 1'b1 == deg_q) ? S_DIV : S_MUL;
				end
				S_DIV: begin
					if (h == '0) begin
						// weight sum zero: flag and zero point
						done <= 1'b1;
						zero_weight_sum <= 1'b1;
						curve_x <= '0;
						curve_y <= '0;
						curve_z <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: if (div_done[0]) begin
					done <= 1'b1;
					zero_weight_sum <= 1'b0;
					curve_x <= qx;
					curve_y <= qy;
					curve_z <= qz;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RBEZ_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`RBEZ_ASSERT_NEXT(a_eval_busy, clk, arst_n, accept && opcode, busy)
	`RBEZ_ASSERT_NOW(a_zero_point, clk, arst_n, done && zero_weight_sum,
		curve_x == '0 && curve_y == '0 && curve_z == '0)
	`RBEZ_ASSERT_NOW(a_div_lockstep, clk, arst_n, div_done[0],
		div_done[1] && div_done[2] && state_q == S_WAIT)
endmodule
